>>> hdl/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and constants for the vertex rotate and project pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int CRD_W     = 24;
  localparam int PIX_W     = 16;
  localparam int DIV_STEPS = 16;
  localparam int REM_W     = 42;
  localparam int ROUND_SH  = 30;

  // Q2.30 rotation coefficients, row major
  localparam logic signed [31:0] ROT_M [3][3] = '{
    '{32'sd1073634453, -32'sd10629337,   32'sd10843536},
    '{32'sd10736702,    32'sd1073635527, -32'sd10629337},
    '{-32'sd10737239,   32'sd10736702,   32'sd1073634453}
  };

  localparam logic [15:0] FOCAL_RST = 16'd1500;
  localparam logic [15:0] PIVOT_RST = 16'd275;
  localparam logic [11:0] CTR_X_RST = 12'd720;
  localparam logic [11:0] CTR_Y_RST = 12'd460;

  typedef enum logic [1:0] {
    REG_FOCAL = 2'd0,
    REG_PIVOT = 2'd1,
    REG_CTR_X = 2'd2,
    REG_CTR_Y = 2'd3
  } vrp_reg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] coord_x;
    logic signed [CRD_W-1:0] coord_y;
    logic signed [CRD_W-1:0] coord_z;
  } vrp_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    behind_camera;
    logic signed [CRD_W-1:0] rotated_x;
    logic signed [CRD_W-1:0] rotated_y;
    logic signed [CRD_W-1:0] rotated_z;
  } vrp_out_t;

  // One slot of the divider chain: both axes share one divisor
  typedef struct packed {
    logic                    valid;
    logic [REM_W-1:0]        rem_x;
    logic [REM_W-1:0]        rem_y;
    logic [REM_W-1:0]        dsh;
    logic [PIX_W-1:0]        q_x;
    logic [PIX_W-1:0]        q_y;
    logic                    neg_x;
    logic                    neg_y;
    logic                    ovf_x;
    logic                    ovf_y;
    logic                    behind;
    logic signed [CRD_W-1:0] rot_x;
    logic signed [CRD_W-1:0] rot_y;
    logic signed [CRD_W-1:0] rot_z;
  } vrp_div_t;

endpackage

`default_nettype wire

>>> hdl/vrp_div_stage.sv
// ----------------------------------------------------------------------------
// vrp_div_stage
// One restoring-division step for both projection axes, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_div_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vrp_pkg::vrp_div_t d_in,
  output vrp_pkg::vrp_div_t      d_out
);

  vrp_pkg::vrp_div_t slot_r;
  vrp_pkg::vrp_div_t slot_nxt;
  logic [vrp_pkg::REM_W-1:0] half;
  logic                      bit_x;
  logic                      bit_y;

  // Halve the shifted divisor, then subtract where it fits
  always_comb begin
    half          = d_in.dsh >> 1;
    bit_x         = d_in.rem_x >= half;
    bit_y         = d_in.rem_y >= half;
    slot_nxt      = d_in;
    slot_nxt.dsh  = half;
    slot_nxt.rem_x = bit_x ? d_in.rem_x - half : d_in.rem_x;
    slot_nxt.rem_y = bit_y ? d_in.rem_y - half : d_in.rem_y;
    slot_nxt.q_x  = {d_in.q_x[vrp_pkg::PIX_W-2:0], bit_x};
    slot_nxt.q_y  = {d_in.q_y[vrp_pkg::PIX_W-2:0], bit_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign d_out = slot_r;

endmodule

`default_nettype wire

>>> hdl/vertex_rotate_and_project.sv
// ----------------------------------------------------------------------------
// vertex_rotate_and_project
// Perspective projection of a fixed-point vertex plus a fixed small-angle
// rotation about a z pivot, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  -------------------------
//  input    start, busy, in_data                    request taken: start & !busy
//  result   out_valid, out_data                     one-cycle strobe, no stall
//  config   psel penable pwrite paddr pwdata        APB, pready tied high
//           prdata pready
//
//  One request enters every cycle; busy is never raised.
//  The pipeline holds five arithmetic stages, sixteen divider steps
//  (one quotient bit per step, the divider chain sets the depth) and the
//  output register.
//  Synchronous active-low reset drops all requests in flight and restores
//  the register defaults. The receiver cannot stall, so nothing holds.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_rotate_and_project (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire vrp_pkg::vrp_in_t  in_data,
  output logic                   out_valid,
  output vrp_pkg::vrp_out_t      out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] focal_r;
  logic [15:0] pivot_r;
  logic [11:0] ctr_x_r;
  logic [11:0] ctr_y_r;
  vrp_pkg::vrp_reg_t reg_sel;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = vrp_pkg::vrp_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= vrp_pkg::FOCAL_RST;
      pivot_r <= vrp_pkg::PIVOT_RST;
      ctr_x_r <= vrp_pkg::CTR_X_RST;
      ctr_y_r <= vrp_pkg::CTR_Y_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        vrp_pkg::REG_FOCAL: focal_r <= pwdata[15:0];
        vrp_pkg::REG_PIVOT: pivot_r <= pwdata[15:0];
        vrp_pkg::REG_CTR_X: ctr_x_r <= pwdata[11:0];
        vrp_pkg::REG_CTR_Y: ctr_y_r <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      vrp_pkg::REG_FOCAL: prdata = {16'h0, focal_r};
      vrp_pkg::REG_PIVOT: prdata = {{16{pivot_r[15]}}, pivot_r};
      vrp_pkg::REG_CTR_X: prdata = {20'h0, ctr_x_r};
      vrp_pkg::REG_CTR_Y: prdata = {20'h0, ctr_y_r};
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the request
  // --------------------------------------------------------------------------
  logic             s1_v_r;
  vrp_pkg::vrp_in_t s1_in_r;

  always_ff @(posedge clk) begin
    s1_in_r <= in_data;
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: depth D = f*2^FRAC + z, focal products, pivot-relative z
  // --------------------------------------------------------------------------
  logic               s2_v_r;
  logic signed [25:0] s2_d_r,  s2_d_nxt;
  logic signed [40:0] s2_fx_r, s2_fx_nxt;
  logic signed [40:0] s2_fy_r, s2_fy_nxt;
  logic signed [24:0] s2_vx_r, s2_vy_r, s2_vz_r, s2_vz_nxt;
  logic signed [23:0] piv_fix;

  assign piv_fix = $signed({pivot_r, {vrp_pkg::FRAC_BITS{1'b0}}});

  always_comb begin
    s2_d_nxt  = $signed({2'b00, focal_r, {vrp_pkg::FRAC_BITS{1'b0}}})
              + 26'(s1_in_r.coord_z);
    s2_fx_nxt = $signed({1'b0, focal_r}) * s1_in_r.coord_x;
    s2_fy_nxt = $signed({1'b0, focal_r}) * s1_in_r.coord_y;
    s2_vz_nxt = 25'(s1_in_r.coord_z) - 25'(piv_fix);
  end

  always_ff @(posedge clk) begin
    s2_d_r  <= s2_d_nxt;
    s2_fx_r <= s2_fx_nxt;
    s2_fy_r <= s2_fy_nxt;
    s2_vx_r <= 25'(s1_in_r.coord_x);
    s2_vy_r <= 25'(s1_in_r.coord_y);
    s2_vz_r <= s2_vz_nxt;
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: center*D and the nine matrix products
  // --------------------------------------------------------------------------
  logic               s3_v_r;
  logic               s3_behind_r;
  logic [24:0]        s3_d_r;
  logic signed [40:0] s3_fx_r, s3_fy_r;
  logic signed [38:0] s3_cxd_r, s3_cyd_r;
  logic signed [56:0] s3_p_r [3][3];
  logic signed [24:0] s2_vec [3];

  assign s2_vec[0] = s2_vx_r;
  assign s2_vec[1] = s2_vy_r;
  assign s2_vec[2] = s2_vz_r;

  always_ff @(posedge clk) begin
    s3_behind_r <= (s2_d_r <= 26'sd0);
    s3_d_r      <= s2_d_r[24:0];
    s3_fx_r     <= s2_fx_r;
    s3_fy_r     <= s2_fy_r;
    s3_cxd_r    <= $signed({1'b0, ctr_x_r}) * s2_d_r;
    s3_cyd_r    <= $signed({1'b0, ctr_y_r}) * s2_d_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_p_r[i][j] <= vrp_pkg::ROT_M[i][j] * s2_vec[j];
      end
    end
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: numerators and their magnitudes, rounded row sums
  // --------------------------------------------------------------------------
  logic                      s4_v_r;
  logic                      s4_behind_r;
  logic [24:0]               s4_d_r;
  logic [vrp_pkg::REM_W-1:0] s4_ax_r, s4_ay_r;
  logic                      s4_nx_r, s4_ny_r;
  logic signed [28:0]        s4_r_r [3];
  logic signed [41:0]        num_x, num_y;
  logic signed [58:0]        row_sum [3];

  always_comb begin
    num_x = 42'(s3_fx_r) + 42'(s3_cxd_r);
    num_y = 42'(s3_fy_r) + 42'(s3_cyd_r);
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = 59'(s3_p_r[i][0]) + 59'(s3_p_r[i][1]) + 59'(s3_p_r[i][2])
                 + (59'sd1 <<< (vrp_pkg::ROUND_SH - 1));
    end
  end

  always_ff @(posedge clk) begin
    s4_behind_r <= s3_behind_r;
    s4_d_r      <= s3_d_r;
    s4_nx_r     <= num_x[41];
    s4_ny_r     <= num_y[41];
    s4_ax_r     <= num_x[41] ? 42'(-num_x) : 42'(num_x);
    s4_ay_r     <= num_y[41] ? 42'(-num_y) : 42'(num_y);
    for (int i = 0; i < 3; i++) begin
      s4_r_r[i] <= 29'(row_sum[i] >>> vrp_pkg::ROUND_SH);
    end
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: quotient overflow check, pivot add-back and rotation clamp
  // --------------------------------------------------------------------------
  vrp_pkg::vrp_div_t  dv [vrp_pkg::DIV_STEPS+1];
  vrp_pkg::vrp_div_t  s5_nxt;
  vrp_pkg::vrp_div_t  s5_r;
  logic [vrp_pkg::REM_W-1:0] dsh_top;
  logic signed [29:0] rz_full;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    logic signed [23:0] res;
    if (v > 30'sd8388607) begin
      res = 24'sd8388607;
    end else if (v < -30'sd8388608) begin
      res = -24'sd8388608;
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

  always_comb begin
    dsh_top       = {1'b0, s4_d_r, {vrp_pkg::DIV_STEPS{1'b0}}};
    rz_full       = 30'(s4_r_r[2]) + 30'(piv_fix);
    s5_nxt.valid  = s4_v_r;
    s5_nxt.rem_x  = s4_ax_r;
    s5_nxt.rem_y  = s4_ay_r;
    s5_nxt.dsh    = dsh_top;
    s5_nxt.q_x    = '0;
    s5_nxt.q_y    = '0;
    s5_nxt.neg_x  = s4_nx_r;
    s5_nxt.neg_y  = s4_ny_r;
    s5_nxt.ovf_x  = s4_ax_r >= dsh_top;
    s5_nxt.ovf_y  = s4_ay_r >= dsh_top;
    s5_nxt.behind = s4_behind_r;
    s5_nxt.rot_x  = sat24(30'(s4_r_r[0]));
    s5_nxt.rot_y  = sat24(30'(s4_r_r[1]));
    s5_nxt.rot_z  = sat24(rz_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r <= '0;
    end else begin
      s5_r <= s5_nxt;
    end
  end

  assign dv[0] = s5_r;

  // --------------------------------------------------------------------------
  // Divider chain: one quotient bit per stage, most significant first
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < vrp_pkg::DIV_STEPS; k++) begin : g_div
    vrp_div_stage u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (dv[k]),
      .d_out (dv[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output: apply sign, saturate to 16 bits, zero the pixel when behind
  // --------------------------------------------------------------------------
  vrp_pkg::vrp_div_t dl;
  vrp_pkg::vrp_out_t out_nxt;
  logic              out_valid_r;
  vrp_pkg::vrp_out_t out_data_r;

  function automatic logic signed [15:0] pix_sat(input logic [15:0] q,
                                                 input logic neg, input logic ovf);
    logic signed [15:0] res;
    if (neg) begin
      if (ovf || (q > 16'd32768)) begin
        res = -16'sd32768;
      end else begin
        res = 16'(-q);
      end
    end else begin
      if (ovf || q[15]) begin
        res = 16'sd32767;
      end else begin
        res = q;
      end
    end
    return res;
  endfunction

  assign dl = dv[vrp_pkg::DIV_STEPS];

  always_comb begin
    out_nxt.behind_camera = dl.behind;
    out_nxt.pixel_x   = dl.behind ? '0 : pix_sat(dl.q_x, dl.neg_x, dl.ovf_x);
    out_nxt.pixel_y   = dl.behind ? '0 : pix_sat(dl.q_y, dl.neg_y, dl.ovf_y);
    out_nxt.rotated_x = dl.rot_x;
    out_nxt.rotated_y = dl.rot_y;
    out_nxt.rotated_z = dl.rot_z;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dl.valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.behind_camera |->
      (out_data.pixel_x == '0) && (out_data.pixel_y == '0))
    else $error("behind-camera result carries a nonzero pixel");

  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    dl.valid && !dl.behind && !dl.ovf_x |-> dl.rem_x < dl.dsh)
    else $error("x remainder not below divisor after last step");

  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    dl.valid && !dl.behind && !dl.ovf_y |-> dl.rem_y < dl.dsh)
    else $error("y remainder not below divisor after last step");

endmodule

`default_nettype wire

>>> tb/sv/tb_vertex_rotate_and_project.sv
// ----------------------------------------------------------------------------
// tb_vertex_rotate_and_project
// Self-checking bench for the vertex projection and rotation pipeline. An
// integer projector/rotator class predicts every result; requests are
// driven with random gaps and the four registers are swept between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vertex_rotate_and_project;
  timeunit 1ns;
  timeprecision 1ps;

  // Holds a shadow copy of the registers and the pending projected vertices.
  class vertex_scoreboard;
    longint unsigned   focal;
    longint            pivot;
    longint unsigned   ctr_x;
    longint unsigned   ctr_y;
    vrp_pkg::vrp_out_t pending[$];
    int                errors;
    int                checked;
    int                behind_seen;

    function new();
      focal = longint'(vrp_pkg::FOCAL_RST);
      pivot = longint'($signed(vrp_pkg::PIVOT_RST));
      ctr_x = longint'(vrp_pkg::CTR_X_RST);
      ctr_y = longint'(vrp_pkg::CTR_Y_RST);
    endfunction

    function void set_reg(vrp_pkg::vrp_reg_t idx, logic [31:0] val);
      case (idx)
        vrp_pkg::REG_FOCAL: focal = longint'(val[15:0]);
        vrp_pkg::REG_PIVOT: pivot = longint'($signed(val[15:0]));
        vrp_pkg::REG_CTR_X: ctr_x = longint'(val[11:0]);
        vrp_pkg::REG_CTR_Y: ctr_y = longint'(val[11:0]);
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Project and rotate one vertex; queue the expected result.
    function void note_request(vrp_pkg::vrp_in_t vtx);
      longint            x, y, z, depth, piv, acc;
      longint            vec[3];
      longint            rot[3];
      vrp_pkg::vrp_out_t exp_res;
      x = longint'(vtx.coord_x);
      y = longint'(vtx.coord_y);
      z = longint'(vtx.coord_z);
      depth = longint'(focal) * (64'sd1 << vrp_pkg::FRAC_BITS) + z;
      piv = pivot * (64'sd1 << vrp_pkg::FRAC_BITS);
      exp_res = '0;
      if (depth > 0) begin
        // C-style division truncates toward zero, as SV does
        exp_res.pixel_x = 16'(sat((longint'(focal) * x + longint'(ctr_x) * depth) / depth,
                                  -32768, 32767));
        exp_res.pixel_y = 16'(sat((longint'(focal) * y + longint'(ctr_y) * depth) / depth,
                                  -32768, 32767));
      end else begin
        exp_res.behind_camera = 1'b1;
      end
      vec[0] = x;
      vec[1] = y;
      vec[2] = z - piv;
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) acc += longint'(vrp_pkg::ROT_M[r][c]) * vec[c];
        // round half up: floor((acc + 2^29) / 2^30)
        rot[r] = (acc + (64'sd1 << (vrp_pkg::ROUND_SH - 1))) >>> vrp_pkg::ROUND_SH;
      end
      rot[2] += piv;
      exp_res.rotated_x = 24'(sat(rot[0], -8388608, 8388607));
      exp_res.rotated_y = 24'(sat(rot[1], -8388608, 8388607));
      exp_res.rotated_z = 24'(sat(rot[2], -8388608, 8388607));
      pending = {pending, exp_res};
    endfunction

    function void check_result(vrp_pkg::vrp_out_t got);
      vrp_pkg::vrp_out_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (w.behind_camera) behind_seen++;
      if (got.pixel_x !== w.pixel_x)
        $display("%0t: pixel_x exp %0d got %0d", $time, w.pixel_x, got.pixel_x);
      if (got.pixel_y !== w.pixel_y)
        $display("%0t: pixel_y exp %0d got %0d", $time, w.pixel_y, got.pixel_y);
      if (got.behind_camera !== w.behind_camera)
        $display("%0t: behind_camera exp %0b got %0b", $time,
                 w.behind_camera, got.behind_camera);
      if (got.rotated_x !== w.rotated_x)
        $display("%0t: rotated_x exp %0d got %0d", $time, w.rotated_x, got.rotated_x);
      if (got.rotated_y !== w.rotated_y)
        $display("%0t: rotated_y exp %0d got %0d", $time, w.rotated_y, got.rotated_y);
      if (got.rotated_z !== w.rotated_z)
        $display("%0t: rotated_z exp %0d got %0d", $time, w.rotated_z, got.rotated_z);
      if (got !== w) errors++;
    endfunction
  endclass

  localparam int LATENCY   = 22;
  localparam int MAX_CYCLE = 400000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  vrp_pkg::vrp_in_t  in_data = '0;
  logic              out_valid;
  vrp_pkg::vrp_out_t out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  vertex_scoreboard vsb = new();
  int  cycle_cnt = 0;
  int  calm_left = 0;   // requests left in the current stretch with no gaps

  always #5 clk = ~clk;

  vertex_rotate_and_project u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Results cannot be stalled: check every strobe at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) vsb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("%0t: timeout, %0d results outstanding", $time, vsb.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write one register: setup cycle, then access until pready, then idle.
  task automatic write_reg(vrp_pkg::vrp_reg_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    vsb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipe, then load a full register set; upper bits get noise.
  task automatic load_config(logic [15:0] f, logic [15:0] p, logic [11:0] cx,
                             logic [11:0] cy);
    start <= 1'b0;
    while (vsb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(vrp_pkg::REG_FOCAL, {16'($urandom), f});
    write_reg(vrp_pkg::REG_PIVOT, {16'($urandom), p});
    write_reg(vrp_pkg::REG_CTR_X, {20'($urandom), cx});
    write_reg(vrp_pkg::REG_CTR_Y, {20'($urandom), cy});
    @(posedge clk);
  endtask

  // Issue one request and hold it until taken; then idle cycle by cycle.
  task automatic issue_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    vrp_pkg::vrp_in_t v;
    v.coord_x = x;
    v.coord_y = y;
    v.coord_z = z;
    start   <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    vsb.note_request(v);
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      while ($urandom_range(99) < 27) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  function automatic logic [23:0] pick_coord(int mode);
    case (mode)
      0: return 24'($signed($urandom_range(0, 2 * 1000 * 256)) - 1000 * 256);
      1: return 24'($urandom);
      default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  // Random vertices: mostly scene-sized, some full range, some hugging
  // the camera plane so behind-camera and near-plane overflow show up.
  task automatic random_phase(int count);
    longint plane, zv;
    int     mode;
    logic [23:0] z;
    for (int n = 0; n < count; n++) begin
      if (calm_left == 0 && $urandom_range(299) == 0) calm_left = 80;
      mode = $urandom_range(99);
      if (mode < 55) begin
        issue_vertex(pick_coord(0), pick_coord(0), pick_coord(0));
      end else if (mode < 80) begin
        issue_vertex(pick_coord(1), pick_coord(1), pick_coord(1));
      end else if (mode < 93) begin
        plane = -longint'(vsb.focal) * 256;
        zv = plane + $signed($urandom_range(0, 64)) - 32;
        z = (zv >= -8388608 && zv <= 8388607) ? 24'(zv) : pick_coord(1);
        issue_vertex(pick_coord(0), pick_coord(1), z);
      end else begin
        issue_vertex(pick_coord(2), pick_coord(2), pick_coord($urandom_range(1, 2)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed at reset defaults: origin, extremes, the camera plane itself,
    // one step in front of it, and a vertex that overflows the pixel range.
    issue_vertex(24'h0, 24'h0, 24'h0);
    issue_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    issue_vertex(24'h800000, 24'h800000, 24'h800000);
    issue_vertex(24'h7FFFFF, 24'h800000, 24'h0);
    issue_vertex(24'h100, 24'h100, 24'(-1500 * 256));
    issue_vertex(24'h100, 24'h100, 24'(-1500 * 256 + 1));
    issue_vertex(24'h7FFFFF, 24'h800000, 24'(-1500 * 256 + 1));
    issue_vertex(24'h555555, 24'hAAAAAA, 24'h123456);
    issue_vertex(24'hAAAAAA, 24'h555555, 24'hEDCBA9);
    issue_vertex(24'h0, 24'h0, 24'(275 * 256));
    // Focal length zero: depth is z alone.
    load_config(16'd0, 16'h8000, 12'd0, 12'd4095);
    issue_vertex(24'h1000, 24'hFFF000, 24'h0);
    issue_vertex(24'h1000, 24'hFFF000, 24'h1);
    issue_vertex(24'h7FFFFF, 24'h800000, 24'h1);
    issue_vertex(24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    issue_vertex(24'h0, 24'h0, 24'h800000);
    random_phase(200);

    load_config(16'd1500, 16'd275, 12'd720, 12'd460);
    random_phase(400);
    load_config(16'd65535, 16'h7FFF, 12'd4095, 12'd0);
    random_phase(250);
    load_config(16'd1, 16'h8000, 12'd2048, 12'd4095);
    random_phase(250);
    load_config(16'($urandom_range(1, 65535)), 16'($urandom), 12'($urandom),
                12'($urandom));
    random_phase(300);
    load_config(16'($urandom_range(100, 4000)), 16'($urandom_range(0, 600)),
                12'($urandom), 12'($urandom));
    random_phase(330);

    start <= 1'b0;
    while (vsb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Checked %0d projected vertices (%0d behind the camera) over seven",
             vsb.checked, vsb.behind_seen);
    $display("register settings, focal length swept from 0 to 65535.");
    if (vsb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire

>>> vertex_rotate_and_project.f
hdl/vrp_pkg.sv
hdl/vrp_div_stage.sv
hdl/vertex_rotate_and_project.sv
tb/sv/tb_vertex_rotate_and_project.sv
